// ----- design/lbs_pkg.sv -----
package lbs_pkg;

    // Matrix words per joint: three rows of four, row*4+col.
    localparam int MAT_WORDS = 12;
    localparam int DEF_JOINT_COUNT = 64;
    localparam logic [15:0] WEIGHT_ONE = 16'd32768;
    localparam logic [3:0] LAST_ELEM = 4'd11;
    localparam logic [1:0] TRANS_COL = 2'd3;

    // Width of one row sum: three shifted products plus a translation.
    localparam int ROW_W = 51;
    localparam int WPROD_W = ROW_W + 17;

    typedef enum logic {
        CMD_PALETTE = 1'b0,
        CMD_VERTEX  = 1'b1
    } cmd_kind_t;

    // One classified item as it sits in the queue.
    typedef struct packed {
        cmd_kind_t   kind;
        logic        contrib;
        logic        last;
        logic [5:0]  joint;
        logic [3:0]  elem;
        logic [31:0] value;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [15:0] weight;
    } cmd_t;

    // Status of the back part.
    typedef struct packed {
        logic idle;
        logic pipe_busy;
    } back_stat_t;

    // Clamp a 64-bit sum to Q16.16; the top bit of the result is the clamp flag.
    function automatic logic [32:0] clamp_q16(input logic [63:0] acc);
        logic [32:0] res;
        res = {1'b0, acc[31:0]};
        if (!acc[63] && (acc[62:31] != '0)) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (acc[63] && (acc[62:31] != '1)) begin
            res = {1'b1, 32'h8000_0000};
        end
        return res;
    endfunction

endpackage

// ----- design/lbs_front.sv -----
module lbs_front import lbs_pkg::*; #(
    parameter int JOINT_COUNT = DEF_JOINT_COUNT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         q_valid,
    output cmd_t         q_data,
    input  logic         q_pop
);

    cmd_t        fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    cmd_t        cmd;
    logic        joint_ok;
    logic        keep;
    logic        push;

    // Classify the incoming item.
    always_comb begin
        cmd.kind    = cmd_kind_t'(s_tuser);
        cmd.joint   = s_tdata[5:0];
        cmd.elem    = s_tdata[9:6];
        cmd.value   = s_tdata[41:10];
        cmd.bx      = s_tdata[73:42];
        cmd.by      = s_tdata[105:74];
        cmd.bz      = s_tdata[137:106];
        cmd.nx      = s_tdata[169:138];
        cmd.ny      = s_tdata[201:170];
        cmd.nz      = s_tdata[233:202];
        cmd.weight  = (s_tdata[249:234] > WEIGHT_ONE) ? WEIGHT_ONE : s_tdata[249:234];
        cmd.last    = s_tlast;
        joint_ok    = (9'(s_tdata[5:0]) < 9'(JOINT_COUNT));
        cmd.contrib = joint_ok && (cmd.weight != '0);
        if (cmd.kind == CMD_PALETTE) begin
            keep = joint_ok && (cmd.elem <= LAST_ELEM);
        end else begin
            keep = cmd.contrib || cmd.last;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = fifo_reg[rd_ptr_reg];

    // Queue pointers.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// ----- design/lbs_back.sv -----
module lbs_back import lbs_pkg::*; #(
    parameter int JOINT_COUNT = DEF_JOINT_COUNT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         has_normals,
    input  logic         q_valid,
    input  cmd_t         q_data,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    output logic         m_tuser,
    output back_stat_t   stat
);

    localparam int ADDR_W = $clog2(JOINT_COUNT * MAT_WORDS);
    localparam int DEPTH = JOINT_COUNT * MAT_WORDS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cur_reg;
    logic [3:0] elem_reg, elem_next;

    logic [31:0] palette [DEPTH];
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]  col1_reg, col2_reg, row1_reg, row2_reg, row3_reg, row4_reg;
    logic [31:0] memq_reg, wd2_reg;
    logic signed [63:0] prodp_reg, prodn_reg;
    logic signed [ROW_W-1:0] rowp_reg, rown_reg;
    logic signed [ROW_W-1:0] termp, termn;
    logic signed [WPROD_W-1:0] wpp_reg, wpn_reg;
    logic signed [16:0] w_s;
    logic [31:0] coord_p, coord_n;
    logic [63:0] pos_acc_reg [3];
    logic [63:0] nrm_acc_reg [3];

    logic        out_valid_reg;
    logic [191:0] out_data_reg;
    logic        out_sat_reg;
    logic        emit_fire;
    logic [32:0] cx, cy, cz, cnx, cny, cnz;

    assign wr_addr = ADDR_W'({q_data.joint, 3'b000}) + ADDR_W'({q_data.joint, 2'b00})
                   + ADDR_W'(q_data.elem);
    assign rd_addr = ADDR_W'({cur_reg.joint, 3'b000}) + ADDR_W'({cur_reg.joint, 2'b00})
                   + ADDR_W'(elem_reg);
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    // Sequencer: one palette word fetched per cycle during issue.
    always_comb begin
        state_next = state_reg;
        elem_next  = elem_reg;
        unique case (state_reg)
            ST_IDLE: begin
                elem_next = 4'd0;
                if (q_valid && q_data.kind == CMD_VERTEX) begin
                    state_next = q_data.contrib ? ST_ISSUE : ST_EMIT;
                end
            end
            ST_ISSUE: begin
                elem_next = elem_reg + 4'd1;
                if (elem_reg == LAST_ELEM) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = cur_reg.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            elem_reg  <= 4'd0;
        end else begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
        end
        if (q_pop) begin
            cur_reg <= q_data;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (q_pop && q_data.kind == CMD_PALETTE) begin
            palette[wr_addr] <= q_data.value;
        end
        memq_reg <= palette[rd_addr];
    end

    // Coordinate for the current column.
    always_comb begin
        case (col1_reg)
            2'd0:    begin coord_p = cur_reg.bx; coord_n = cur_reg.nx; end
            2'd1:    begin coord_p = cur_reg.by; coord_n = cur_reg.ny; end
            default: begin coord_p = cur_reg.bz; coord_n = cur_reg.nz; end
        endcase
    end

    // Row terms: translation in the last column, shifted products elsewhere.
    always_comb begin
        if (col2_reg == TRANS_COL) begin
            termp = ROW_W'($signed(wd2_reg));
            termn = '0;
        end else begin
            termp = ROW_W'(prodp_reg >>> 16);
            termn = ROW_W'(prodn_reg >>> 16);
        end
    end

    assign w_s = $signed({1'b0, cur_reg.weight});

    // Arithmetic pipeline: products, row sums, weighting, accumulation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                pos_acc_reg[i] <= '0;
                nrm_acc_reg[i] <= '0;
            end
        end else begin
            v1_reg <= (state_reg == ST_ISSUE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (col2_reg == TRANS_COL);
            v4_reg <= v3_reg;
            if (v4_reg) begin
                pos_acc_reg[row4_reg] <= pos_acc_reg[row4_reg] + 64'(wpp_reg >>> 15);
                if (has_normals) begin
                    nrm_acc_reg[row4_reg] <= nrm_acc_reg[row4_reg] + 64'(wpn_reg >>> 15);
                end
            end
            if (emit_fire) begin
                for (int i = 0; i < 3; i++) begin
                    pos_acc_reg[i] <= '0;
                    nrm_acc_reg[i] <= '0;
                end
            end
        end
        col1_reg  <= elem_reg[1:0];
        row1_reg  <= elem_reg[3:2];
        col2_reg  <= col1_reg;
        row2_reg  <= row1_reg;
        wd2_reg   <= memq_reg;
        prodp_reg <= $signed(memq_reg) * $signed(coord_p);
        prodn_reg <= $signed(memq_reg) * $signed(coord_n);
        if (v2_reg) begin
            rowp_reg <= ((col2_reg == 2'd0) ? '0 : rowp_reg) + termp;
            rown_reg <= ((col2_reg == 2'd0) ? '0 : rown_reg) + termn;
        end
        row3_reg <= row2_reg;
        row4_reg <= row3_reg;
        wpp_reg  <= rowp_reg * w_s;
        wpn_reg  <= rown_reg * w_s;
    end

    // Saturation of the sums.
    always_comb begin
        cx  = clamp_q16(pos_acc_reg[0]);
        cy  = clamp_q16(pos_acc_reg[1]);
        cz  = clamp_q16(pos_acc_reg[2]);
        cnx = has_normals ? clamp_q16(nrm_acc_reg[0]) : '0;
        cny = has_normals ? clamp_q16(nrm_acc_reg[1]) : '0;
        cnz = has_normals ? clamp_q16(nrm_acc_reg[2]) : '0;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (emit_fire) begin
            out_data_reg <= {cnz[31:0], cny[31:0], cnx[31:0], cz[31:0], cy[31:0], cx[31:0]};
            out_sat_reg  <= cx[32] | cy[32] | cz[32] | cnx[32] | cny[32] | cnz[32];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// ----- design/linear_blend_skinning.sv -----
// Channel   | Signals                         | Content
// s_ (in)   | s_tvalid s_tready s_tdata[255:0] | item; tuser = mode, tlast = last_of_vertex
//           | s_tuser s_tlast                 |
// m_ (out)  | m_tvalid m_tready m_tdata[191:0] | result; tuser = saturated
//           | m_tuser                         |
// cfg       | cfg_we cfg_wdata                | has_normals
//
// A palette item is written to the palette from the idle state. A weighted vertex item
// reads its twelve matrix words one per cycle from the single palette read port, then
// waits for the multiply pipeline to drain. The input queue holds two items so the
// front keeps accepting while the back works or the output stalls, until the queue is full.
// Reset is synchronous, active low; the palette is not cleared.
module linear_blend_skinning import lbs_pkg::*; #(
    parameter int JOINT_COUNT = DEF_JOINT_COUNT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // joint[5:0] palette_elem[9:6] palette_value[41:10] bind_x[73:42] bind_y[105:74]
    // bind_z[137:106] normal_x[169:138] normal_y[201:170] normal_z[233:202]
    // blend_weight[249:234], zero above
    input  logic [255:0] s_tdata,
    // mode
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // skinned_x[31:0] skinned_y[63:32] skinned_z[95:64] skinned_nx[127:96]
    // skinned_ny[159:128] skinned_nz[191:160]
    output logic [191:0] m_tdata,
    // saturated
    output logic         m_tuser
);

    logic       has_normals_reg;
    logic       q_valid;
    cmd_t       q_data;
    logic       q_pop;
    back_stat_t bk_stat;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_normals_reg <= 1'b1;
        end else if (cfg_we) begin
            has_normals_reg <= cfg_wdata;
        end
    end

    lbs_front #(.JOINT_COUNT(JOINT_COUNT)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    lbs_back #(.JOINT_COUNT(JOINT_COUNT)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .has_normals (has_normals_reg),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .stat        (bk_stat)
    );

    // With normals off, the emitted normals are zero.
    a_normals_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !has_normals_reg |-> m_tdata[191:96] == '0)
        else $error("normals emitted while disabled");

    // The sequencer only returns to idle once the pipeline has drained.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.idle |-> !bk_stat.pipe_busy)
        else $error("back idle with work in flight");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import lbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_JOINTS = DEF_JOINT_COUNT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;

    // One input item as the driver presents it.
    typedef struct {
        cmd_kind_t   kind;
        logic [5:0]  joint;
        logic [3:0]  elem;
        logic [31:0] value;
        logic [31:0] bind_pos [3];
        logic [31:0] bind_nrm [3];
        logic [15:0] weight;
        logic        last;
    } skin_item_t;

    // One emitted vertex.
    typedef struct {
        logic [191:0] coords;
        logic         clamped;
    } skinned_vertex_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic         cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic         m_tuser;

    linear_blend_skinning uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state.
    logic [31:0]     pal_mirror [NUM_JOINTS*MAT_WORDS];
    bit              pal_written [NUM_JOINTS];
    logic [63:0]     pos_acc [3];
    logic [63:0]     nrm_acc [3];
    logic            normals_on;
    skin_item_t      pending_items [$];
    skinned_vertex_t expected_vertices [$];
    int              mismatch_count;
    longint          cycle_count;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic [32:0] sat_q16(logic [63:0] acc);
        logic signed [63:0] v;
        v = acc;
        if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
        if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
        return {1'b0, acc[31:0]};
    endfunction

    // Applies one accepted item to the predictor.
    task automatic predict_skin(input skin_item_t it);
        logic signed [63:0] t, q, w, m;
        logic [32:0]        c;
        skinned_vertex_t    v;
        int                 base;
        if (it.kind == CMD_PALETTE) begin
            if (it.elem < MAT_WORDS) pal_mirror[it.joint*MAT_WORDS + it.elem] = it.value;
            return;
        end
        w = (it.weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(it.weight);
        base = it.joint * MAT_WORDS;
        if (w != 0) begin
            for (int r = 0; r < 3; r++) begin
                t = 64'($signed(pal_mirror[base + r*4 + 3]));
                q = 0;
                for (int k = 0; k < 3; k++) begin
                    m = 64'($signed(pal_mirror[base + r*4 + k]));
                    t += floor_shr(m * 64'($signed(it.bind_pos[k])), 16);
                    q += floor_shr(m * 64'($signed(it.bind_nrm[k])), 16);
                end
                pos_acc[r] += floor_shr(t * w, 15);
                if (normals_on) nrm_acc[r] += floor_shr(q * w, 15);
            end
        end
        if (!it.last) return;
        v.clamped = 1'b0;
        v.coords = '0;
        for (int r = 0; r < 3; r++) begin
            c = sat_q16(pos_acc[r]);
            v.coords[32*r +: 32] = c[31:0];
            v.clamped |= c[32];
            if (normals_on) begin
                c = sat_q16(nrm_acc[r]);
                v.coords[96 + 32*r +: 32] = c[31:0];
                v.clamped |= c[32];
            end
            pos_acc[r] = '0;
            nrm_acc[r] = '0;
        end
        expected_vertices = {expected_vertices, v};
    endtask

    // Driver: one item at a time, with a random gap before each.
    int        src_gap;
    skin_item_t cur_item;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
            src_gap <= $urandom_range(0, 8);
        end else if (s_tvalid && s_tready) begin
            predict_skin(cur_item);
            s_tvalid <= 1'b0;
            src_gap <= $urandom_range(0, 8);
        end else if (!s_tvalid) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_tdata <= {6'd0, cur_item.weight, cur_item.bind_nrm[2],
                            cur_item.bind_nrm[1], cur_item.bind_nrm[0],
                            cur_item.bind_pos[2], cur_item.bind_pos[1],
                            cur_item.bind_pos[0], cur_item.value, cur_item.elem,
                            cur_item.joint};
                s_tuser <= cur_item.kind;
                s_tlast <= cur_item.last;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Monitor: random stalls on the result side and field-by-field check.
    int sink_gap;
    always @(posedge aclk) begin
        skinned_vertex_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 8);
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_vertices.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected vertex %h", m_tdata);
                end else begin
                    e = expected_vertices.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (m_tdata[32*f +: 32] !== e.coords[32*f +: 32]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("component %0d: expected %h, got %h", f,
                                         e.coords[32*f +: 32], m_tdata[32*f +: 32]);
                        end
                    end
                    if (m_tuser !== e.clamped) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("clamp flag: expected %b, got %b", e.clamped, m_tuser);
                    end
                end
                m_tready <= 1'b0;
                sink_gap <= $urandom_range(0, 8);
            end else if (!m_tready) begin
                if (sink_gap > 0) sink_gap <= sink_gap - 1;
                else m_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** linear_blend_skinning: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic skin_item_t make_palette(int j, int el, logic [31:0] val);
        skin_item_t it;
        it.kind = CMD_PALETTE;
        it.joint = 6'(j);
        it.elem = 4'(el);
        it.value = val;
        for (int k = 0; k < 3; k++) begin
            it.bind_pos[k] = $urandom;
            it.bind_nrm[k] = $urandom;
        end
        it.weight = 16'($urandom);
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic skin_item_t make_vertex(int j, logic [15:0] w, logic lst);
        skin_item_t it;
        it = make_palette(j, $urandom_range(0, 15), $urandom);
        it.kind = CMD_VERTEX;
        for (int k = 0; k < 3; k++) begin
            it.bind_pos[k] = rand_q16();
            it.bind_nrm[k] = rand_q16();
        end
        it.weight = w;
        it.last = lst;
        return it;
    endfunction

    // Appends one item to the pending queue.
    task automatic add_pending(input skin_item_t it);
        pending_items = {pending_items, it};
    endtask

    // Loads a full matrix for one joint so later lookups read written words.
    task automatic load_joint(int j, bit wild);
        for (int el = 0; el < MAT_WORDS; el++) begin
            if (wild) add_pending(make_palette(j, el, rand_q16()));
            else add_pending(make_palette(j, el,
                ((el % 4) == (el / 4)) ? 32'h0001_0000 : $urandom_range(0, 32'h2_0000)));
        end
        pal_written[j] = 1'b1;
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return WEIGHT_ONE;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(1, 32768));
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_vertices.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_normals(logic val);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        normals_on = val;
    endtask

    // Stimulus.
    initial begin
        int nj, j, written [$];
        normals_on = 1'b1;
        for (int k = 0; k < 3; k++) begin
            pos_acc[k] = '0;
            nrm_acc[k] = '0;
        end
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unit-diagonal and extreme matrices, weight edges, ignored writes.
        load_joint(0, 0);
        add_pending(make_palette(0, 12, 32'h7FFF_FFFF));
        add_pending(make_palette(0, 15, 32'h8000_0000));
        add_pending(make_vertex(0, 16'd0, 1'b1));
        add_pending(make_vertex(0, WEIGHT_ONE, 1'b0));
        add_pending(make_vertex(0, 16'hFFFF, 1'b1));
        for (int el = 0; el < MAT_WORDS; el++)
            add_pending(make_palette(63, el, el[0] ? 32'h7FFF_FFFF : 32'h8000_0000));
        pal_written[63] = 1'b1;
        add_pending(make_vertex(63, 16'd1, 1'b0));
        add_pending(make_vertex(63, WEIGHT_ONE, 1'b1));
        wait_idle();

        // Random phases across both normal settings.
        for (int ph = 0; ph < 6; ph++) begin
            set_normals(ph[0] ? 1'b0 : 1'b1);
            written = {};
            for (int k = 0; k < NUM_JOINTS; k++) if (pal_written[k]) written = {written, k};
            for (int n = 0; n < 170; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    j = $urandom_range(0, NUM_JOINTS - 1);
                    load_joint(j, $urandom_range(0, 2) == 0);
                    written = {written, j};
                    n += 11;
                end else begin
                    nj = $urandom_range(1, 4);
                    for (int k = 0; k < nj; k++)
                        add_pending(make_vertex(
                            written[$urandom_range(0, written.size() - 1)],
                            rand_weight(), k == nj - 1));
                    n += nj - 1;
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_vertices.size() == 0) begin
            $display("** linear_blend_skinning: PASSED **");
        end else begin
            $display("** linear_blend_skinning: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/lbs_pkg.sv
design/lbs_front.sv
design/lbs_back.sv
design/linear_blend_skinning.sv
test/tb_top.sv
